// ===== sv/sfr_pkg.sv =====
// Shared types, constants and helpers for the stream find-and-replace block.
`default_nettype none
package sfr_pkg;

  localparam int UNIT_W          = 16;
  localparam int WIN_DEPTH       = 8;
  localparam int PATTERN_MAX     = 8;
  localparam int REPLACEMENT_MAX = 8;
  localparam int REG_UNITS       = 8;
  localparam int LEN_W           = 4;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 64;

  // Register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LOW    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_HIGH   = 3'd5;

  typedef logic [UNIT_W-1:0] unit_t;
  typedef unit_t [WIN_DEPTH-1:0] unit_vec_t;
  typedef logic [LEN_W-1:0] len_t;

  // One result item on its way to the output register
  typedef struct packed {
    unit_t unit;
    logic  last;
    logic  marker;
  } out_item_t;

  // Pattern length in force: zero reads as one, large values saturate
  function automatic len_t eff_pattern_len(input len_t l);
    len_t r;
    r = l;
    if (r == '0) r = len_t'(1);
    if (r > len_t'(PATTERN_MAX)) r = len_t'(PATTERN_MAX);
    if (r > len_t'(REG_UNITS)) r = len_t'(REG_UNITS);
    return r;
  endfunction

  // Replacement length in force
  function automatic len_t eff_replacement_len(input len_t l);
    len_t r;
    r = l;
    if (r > len_t'(REPLACEMENT_MAX)) r = len_t'(REPLACEMENT_MAX);
    if (r > len_t'(REG_UNITS)) r = len_t'(REG_UNITS);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sfr_prefix.sv =====
// Compare unit: tests whether the held window is a prefix of the pattern.
`default_nettype none
module sfr_prefix (
  input  wire sfr_pkg::unit_vec_t window,
  input  wire sfr_pkg::len_t      count,
  input  wire sfr_pkg::unit_vec_t pattern,
  input  wire sfr_pkg::len_t      pattern_len,
  output logic                    is_prefix
);

  logic [sfr_pkg::WIN_DEPTH-1:0] lane_ok;

  // Per-position compare; positions at or past the count always pass
  always_comb begin
    for (int i = 0; i < sfr_pkg::WIN_DEPTH; i++) begin
      lane_ok[i] = (sfr_pkg::len_t'(i) >= count) || (window[i] == pattern[i]);
    end
  end

  assign is_prefix = (count <= pattern_len) && (&lane_ok);

endmodule
`default_nettype wire

// ===== sv/sfr_outreg.sv =====
// Output register for result items, with valid/stall handshake.
`default_nettype none
module sfr_outreg (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  wire sfr_pkg::out_item_t item,
  output logic                    free,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [15:0]             out_unit,
  output logic                    out_last,
  output logic                    marker_only
);

  sfr_pkg::out_item_t held;

  // Room for a new item when empty or when the held one leaves now
  assign free = !out_valid || !out_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      held <= item;
    end
  end

  assign out_unit    = held.unit;
  assign out_last    = held.last;
  assign marker_only = held.marker;

endmodule
`default_nettype wire

// ===== sv/stream_find_replace_top.sv =====
// Top level of the stream find-and-replace block: registers and sequencer.
//
// Streaming find-and-replace-all over 16-bit code units. Items enter on the
// in_* channel (code_unit, end_of_text) and results leave on the out_*
// channel (out_unit, out_last, marker_only); both use valid/stall, with the
// receiver driving stall. Pattern and replacement are written through the
// cfg_* port (index 0..5) while the block is idle; writing the pattern
// length drops any held units. A pending config write holds off input.
//
// One item at a time: in_stall stays high from acceptance until the item's
// results are all handed to the output register. After acceptance the
// sequencer releases units and tests the window in the shared compare unit,
// then makes the replacement units after a match, flushes the held units on
// end of text, and closes in a final state. A result goes to the output
// register when the next one is made or in the closing state.
// The output register decouples the sides; a stalled receiver only holds
// the sequencer when it has a new result to hand over.
// Reset (rst, synchronous) holds off both inputs, empties window and output.
`default_nettype none
module stream_find_replace_top (
  input  wire        clk,
  input  wire        rst,
  // input items
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [15:0] code_unit,
  input  wire        end_of_text,
  // result items
  output logic       out_valid,
  input  wire        out_stall,
  output logic [15:0] out_unit,
  output logic       out_last,
  output logic       marker_only,
  // configuration writes
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [sfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_REPL,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  sfr_pkg::len_t           pattern_length;
  sfr_pkg::len_t           replacement_length;
  logic [sfr_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [sfr_pkg::CFG_DATA_W-1:0] pattern_high;
  logic [sfr_pkg::CFG_DATA_W-1:0] replacement_low;
  logic [sfr_pkg::CFG_DATA_W-1:0] replacement_high;

  // Window and sequencer registers
  sfr_pkg::unit_vec_t window;
  sfr_pkg::len_t      count;
  sfr_pkg::len_t      rep_idx;
  logic               end_flag;
  logic               pend_valid;
  sfr_pkg::unit_t     pend_unit;

  sfr_pkg::unit_vec_t pattern;
  sfr_pkg::unit_vec_t replacement;
  sfr_pkg::len_t      plen;
  sfr_pkg::len_t      rlen;
  logic               is_prefix;
  logic               in_take;
  logic               cfg_take;

  logic               out_free;
  logic               can_push;
  logic               emit;
  logic               fire;
  logic               push;
  sfr_pkg::unit_t     emit_unit;
  sfr_pkg::out_item_t push_item;

  assign pattern     = {pattern_high, pattern_low};
  assign replacement = {replacement_high, replacement_low};
  assign plen        = sfr_pkg::eff_pattern_len(pattern_length);
  assign rlen        = sfr_pkg::eff_replacement_len(replacement_length);

  assign cfg_ready = !rst && (state == ST_IDLE);
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_stall  = rst || (state != ST_IDLE) || cfg_valid;
  assign in_take   = in_valid && !in_stall;

  // Shared compare unit
  sfr_prefix u_prefix (
    .window      (window),
    .count       (count),
    .pattern     (pattern),
    .pattern_len (plen),
    .is_prefix   (is_prefix)
  );

  // Result selection; a new result first pushes the held one out
  assign can_push = !pend_valid || out_free;

  always_comb begin
    emit      = 1'b0;
    emit_unit = window[0];
    push      = 1'b0;
    push_item = '{unit: pend_unit, last: 1'b0, marker: 1'b0};
    unique case (state)
      ST_SHIFT: emit = !is_prefix;
      ST_REPL: begin
        emit      = (rep_idx != rlen);
        emit_unit = replacement[rep_idx[2:0]];
      end
      ST_FLUSH: emit = (count != '0);
      ST_FINISH: begin
        if (pend_valid) begin
          push           = out_free;
          push_item.last = end_flag;
        end else if (end_flag) begin
          push      = out_free;
          push_item = '{unit: '0, last: 1'b1, marker: 1'b1};
        end
      end
      default: ;
    endcase
    fire = emit && can_push;
    if (fire && pend_valid) push = 1'b1;
  end

  sfr_outreg u_outreg (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .item        (push_item),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_unit    (out_unit),
    .out_last    (out_last),
    .marker_only (marker_only)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= sfr_pkg::len_t'(1);
      replacement_length <= '0;
      pattern_low        <= '0;
      pattern_high       <= '0;
      replacement_low    <= '0;
      replacement_high   <= '0;
    end else if (cfg_take) begin
      unique case (cfg_index)
        sfr_pkg::CFG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        sfr_pkg::CFG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        sfr_pkg::CFG_PATTERN_LOW:        pattern_low        <= cfg_data;
        sfr_pkg::CFG_PATTERN_HIGH:       pattern_high       <= cfg_data;
        sfr_pkg::CFG_REPLACEMENT_LOW:    replacement_low    <= cfg_data;
        sfr_pkg::CFG_REPLACEMENT_HIGH:   replacement_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window contents: append on accept, drop the front on release
  always_ff @(posedge clk) begin
    if (in_take) begin
      window[count[2:0]] <= code_unit;
    end else if (fire && (state == ST_SHIFT || state == ST_FLUSH)) begin
      for (int i = 0; i < sfr_pkg::WIN_DEPTH - 1; i++) begin
        window[i] <= window[i+1];
      end
    end
    if (fire) begin
      pend_unit <= emit_unit;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      rep_idx    <= '0;
      end_flag   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (fire) pend_valid <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (cfg_take && cfg_index == sfr_pkg::CFG_PATTERN_LENGTH) begin
            count <= '0;
          end else if (in_take) begin
            count    <= count + sfr_pkg::len_t'(1);
            end_flag <= end_of_text;
            state    <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (!is_prefix) begin
            if (fire) count <= count - sfr_pkg::len_t'(1);
          end else if (count == plen) begin
            count   <= '0;
            rep_idx <= '0;
            state   <= ST_REPL;
          end else begin
            state <= end_flag ? ST_FLUSH : ST_FINISH;
          end
        end
        ST_REPL: begin
          if (rep_idx == rlen) begin
            state <= end_flag ? ST_FLUSH : ST_FINISH;
          end else if (fire) begin
            rep_idx <= rep_idx + sfr_pkg::len_t'(1);
          end
        end
        ST_FLUSH: begin
          if (count == '0) begin
            state <= ST_FINISH;
          end else if (fire) begin
            count <= count - sfr_pkg::len_t'(1);
          end
        end
        ST_FINISH: begin
          if (pend_valid || end_flag) begin
            if (out_free) begin
              pend_valid <= 1'b0;
              state      <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for stream_find_replace_top: predictor, checker, random stimulus.
`timescale 1ns / 100ps
module testbench;

  localparam int SETTLE_CYCLES  = 32;    // quiet time after the last result
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int RANDOM_ITEMS   = 300;
  localparam int REPORT_LIMIT   = 10;

  // Indexes past the register file: writes there must have no effect
  localparam logic [sfr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [sfr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

  // Predicts the rewritten text and checks the block's results against it
  class rewrite_checker;
    sfr_pkg::len_t      pattern_len;
    sfr_pkg::len_t      replacement_len;
    logic [127:0]       pattern_bits;
    logic [127:0]       replacement_bits;
    sfr_pkg::unit_t     held_units[$];
    sfr_pkg::out_item_t rewritten_units[$];
    int                 mismatches;

    function new();
      pattern_len      = sfr_pkg::len_t'(1);
      replacement_len  = '0;
      pattern_bits     = '0;
      replacement_bits = '0;
      mismatches       = 0;
    endfunction

    // Zero length reads as one; both lengths saturate at eight units
    function int active_pattern_len();
      if (pattern_len == 0) return 1;
      if (pattern_len > sfr_pkg::PATTERN_MAX) return sfr_pkg::PATTERN_MAX;
      return int'(pattern_len);
    endfunction

    function int active_replacement_len();
      if (replacement_len > sfr_pkg::REPLACEMENT_MAX) return sfr_pkg::REPLACEMENT_MAX;
      return int'(replacement_len);
    endfunction

    function sfr_pkg::unit_t pattern_unit(int i);
      return pattern_bits[i*sfr_pkg::UNIT_W +: sfr_pkg::UNIT_W];
    endfunction

    function int pending();
      return rewritten_units.size();
    endfunction

    function void apply_write(logic [sfr_pkg::CFG_INDEX_W-1:0] idx,
                              logic [sfr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sfr_pkg::CFG_PATTERN_LENGTH: begin
          pattern_len = data[sfr_pkg::LEN_W-1:0];
          held_units.delete();  // new length drops the window
        end
        sfr_pkg::CFG_REPLACEMENT_LENGTH: replacement_len = data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::CFG_PATTERN_LOW:        pattern_bits[63:0] = data;
        sfr_pkg::CFG_PATTERN_HIGH:       pattern_bits[127:64] = data;
        sfr_pkg::CFG_REPLACEMENT_LOW:    replacement_bits[63:0] = data;
        sfr_pkg::CFG_REPLACEMENT_HIGH:   replacement_bits[127:64] = data;
        default: ;
      endcase
    endfunction

    function bit is_pattern_prefix(sfr_pkg::unit_t w[$], int plen);
      if (w.size() > plen) return 1'b0;
      foreach (w[i])
        if (w[i] != pattern_unit(i)) return 1'b0;
      return 1'b1;
    endfunction

    // One accepted input unit: release, replace, flush
    function void take_unit(sfr_pkg::unit_t u, logic eot);
      sfr_pkg::unit_t     window[$];
      sfr_pkg::out_item_t produced[$];
      sfr_pkg::out_item_t item;
      int                 plen;
      window = held_units;
      window.insert(window.size(), u);
      plen = active_pattern_len();
      // drop units from the front until the window could still start a match
      while (!is_pattern_prefix(window, plen)) begin
        item = {window.pop_front(), 1'b0, 1'b0};
        produced.insert(produced.size(), item);
      end
      // full match: emit the replacement, restart after it
      if (window.size() == plen) begin
        for (int i = 0; i < active_replacement_len(); i++) begin
          item = {replacement_bits[i*sfr_pkg::UNIT_W +: sfr_pkg::UNIT_W], 1'b0, 1'b0};
          produced.insert(produced.size(), item);
        end
        window.delete();
      end
      // end of text: flush, mark the final result
      if (eot) begin
        foreach (window[i]) begin
          item = {window[i], 1'b0, 1'b0};
          produced.insert(produced.size(), item);
        end
        window.delete();
        if (produced.size() == 0) begin
          item = {sfr_pkg::unit_t'(0), 1'b1, 1'b1};
          produced.insert(0, item);
        end else begin
          item = produced.pop_back();
          item.last = 1'b1;
          produced.insert(produced.size(), item);
        end
      end
      held_units = window;
      rewritten_units = {rewritten_units, produced};
    endfunction

    function void report(string what, sfr_pkg::out_item_t want, sfr_pkg::out_item_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s: expected unit %h last %b marker %b, got unit %h last %b marker %b",
                 $realtime, what, want.unit, want.last, want.marker,
                 got.unit, got.last, got.marker);
    endfunction

    function void check_out_unit(sfr_pkg::unit_t u, logic last, logic marker);
      sfr_pkg::out_item_t want;
      sfr_pkg::out_item_t got;
      got = {u, last, marker};
      if (rewritten_units.size() == 0) begin
        report("result with none expected", '0, got);
        return;
      end
      want = rewritten_units.pop_front();
      if (got.unit !== want.unit || got.last !== want.last || got.marker !== want.marker)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [15:0]                     code_unit = '0;
  logic                            end_of_text = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [15:0]                     out_unit;
  logic                            out_last;
  logic                            marker_only;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  rewrite_checker sb;
  bit             steady = 1'b0;  // no idling on either side while set
  sfr_pkg::unit_t alpha_a, alpha_b;
  int             random_items = 0;
  int             idle_cycles = 0;

  stream_find_replace_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .code_unit(code_unit), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_unit(out_unit), .out_last(out_last), .marker_only(marker_only),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if no handshake completes for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** stream_find_replace_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall ahead of each item, check on acceptance
  initial begin : result_sink
    int hold;
    wait (rst == 1'b0);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_out_unit(out_unit, out_last, marker_only);
    end
  end

  // One input item; valid stays up afterwards so a zero gap runs back to back
  task automatic send_unit(input sfr_pkg::unit_t u, input logic eot);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    code_unit   <= u;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_unit(u, eot);
  endtask

  // Hold off input until every predicted result is out, then let it settle
  task automatic drain(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfr_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sfr_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.apply_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // New pattern, lengths and replacement; each register only some of the time
  task automatic randomize_config();
    logic [sfr_pkg::CFG_DATA_W-1:0] word;
    logic [127:0]                   units;
    int                             r;
    if ($urandom_range(0, 4) != 0) begin
      // two-letter alphabet makes self-overlapping patterns common
      alpha_a = sfr_pkg::unit_t'($urandom);
      alpha_b = sfr_pkg::unit_t'($urandom);
      for (int i = 0; i < sfr_pkg::REG_UNITS; i++)
        units[i*sfr_pkg::UNIT_W +: sfr_pkg::UNIT_W] =
          ($urandom_range(0, 3) == 0) ? sfr_pkg::unit_t'($urandom) :
          ($urandom_range(0, 1) ? alpha_a : alpha_b);
      write_reg(sfr_pkg::CFG_PATTERN_LOW, units[63:0]);
      write_reg(sfr_pkg::CFG_PATTERN_HIGH, units[127:64]);
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 9);
      word = {$urandom, $urandom};
      if (r == 0)      word[sfr_pkg::LEN_W-1:0] = '0;
      else if (r == 1) word[sfr_pkg::LEN_W-1:0] = sfr_pkg::len_t'($urandom_range(9, 15));
      else if (r <= 3) word[sfr_pkg::LEN_W-1:0] = sfr_pkg::len_t'($urandom_range(5, 8));
      else             word[sfr_pkg::LEN_W-1:0] = sfr_pkg::len_t'($urandom_range(1, 4));
      write_reg(sfr_pkg::CFG_PATTERN_LENGTH, word);
    end
    if ($urandom_range(0, 2) != 0) begin
      word = {$urandom, $urandom};
      word[sfr_pkg::LEN_W-1:0] = sfr_pkg::len_t'($urandom_range(0, 15));
      write_reg(sfr_pkg::CFG_REPLACEMENT_LENGTH, word);
      write_reg(sfr_pkg::CFG_REPLACEMENT_LOW, {$urandom, $urandom});
      write_reg(sfr_pkg::CFG_REPLACEMENT_HIGH, {$urandom, $urandom});
    end
  endtask

  // Text made mostly of whole patterns and prefixes, plus noise
  task automatic run_text_burst(input int count, input bit end_at_tail);
    sfr_pkg::unit_t queued[$];
    sfr_pkg::unit_t u;
    int             plen;
    int             pick;
    int             n;
    logic           eot;
    plen = sb.active_pattern_len();
    for (int k = 0; k < count; k++) begin
      if (queued.size() == 0) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
          for (int i = 0; i < plen; i++) queued.insert(queued.size(), sb.pattern_unit(i));
        end else if (pick <= 5) begin
          n = $urandom_range(1, plen);
          for (int i = 0; i < n; i++) queued.insert(queued.size(), sb.pattern_unit(i));
        end else if (pick <= 7) begin
          u = $urandom_range(0, 1) ? alpha_a : alpha_b;
          queued.insert(queued.size(), u);
        end else if (pick == 8) begin
          u = sfr_pkg::unit_t'($urandom);
          queued.insert(queued.size(), u);
        end else begin
          // near miss: one bit off a pattern unit
          u = sb.pattern_unit($urandom_range(0, plen - 1));
          u[$urandom_range(0, sfr_pkg::UNIT_W - 1)] ^= 1'b1;
          queued.insert(queued.size(), u);
        end
      end
      u = queued.pop_front();
      eot = ($urandom_range(0, 11) == 0) || (end_at_tail && k == count - 1);
      send_unit(u, eot);
      random_items++;
      if ($urandom_range(0, 24) == 0) drain(0);
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset values: one-unit pattern of zero, empty replacement -> end marker only
    send_unit(16'h0000, 1'b1);

    // zero pattern length reads as one, oversized replacement saturates
    drain(SETTLE_CYCLES);
    write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
    write_reg(sfr_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0000_FFFF);
    write_reg(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_000F);
    write_reg(sfr_pkg::CFG_REPLACEMENT_LOW, {$urandom, $urandom});
    write_reg(sfr_pkg::CFG_REPLACEMENT_HIGH, {$urandom, $urandom});
    write_reg(CFG_SPARE_6, {$urandom, $urandom});
    write_reg(CFG_SPARE_7, {$urandom, $urandom});
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h1234, 1'b0);
    send_unit(16'hFFFF, 1'b1);

    // eight-unit pattern from an oversized length, then a held prefix
    drain(SETTLE_CYCLES);
    write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'h0000_0000_0000_000F);
    write_reg(sfr_pkg::CFG_PATTERN_LOW, 64'h0000_FFFF_0000_FFFF);
    write_reg(sfr_pkg::CFG_PATTERN_HIGH, 64'h0000_FFFF_0000_FFFF);
    write_reg(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_0003);
    write_reg(sfr_pkg::CFG_REPLACEMENT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(sfr_pkg::CFG_REPLACEMENT_HIGH, 64'h0000_0000_0000_0000);
    for (int i = 0; i < 8; i++) send_unit(sb.pattern_unit(i), 1'b0);
    for (int i = 0; i < 3; i++) send_unit(sb.pattern_unit(i), 1'b0);

    // rewriting the pattern length mid-text drops the held units
    drain(SETTLE_CYCLES);
    write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'h0000_0000_0000_0002);
    send_unit(16'h5A5A, 1'b1);

    // pattern units rewritten mid-text: held unit retested against the new pattern
    send_unit(16'hFFFF, 1'b0);
    drain(SETTLE_CYCLES);
    write_reg(sfr_pkg::CFG_PATTERN_LOW, 64'h0000_0000_FFFF_0001);
    send_unit(16'h0001, 1'b0);
    send_unit(16'hFFFF, 1'b1);

    // random phases; a text may stay open across a configuration change
    alpha_a = 16'hFFFF;
    alpha_b = 16'h0001;
    while (random_items < RANDOM_ITEMS) begin
      drain(SETTLE_CYCLES);
      randomize_config();
      steady = ($urandom_range(0, 3) == 0);
      run_text_burst($urandom_range(15, 35), $urandom_range(0, 1));
    end

    drain(SETTLE_CYCLES);
    if (sb.mismatches == 0)
      $display("** stream_find_replace_top: PASSED **");
    else
      $display("** stream_find_replace_top: FAILED **");
    $finish;
  end

endmodule
